/* rtl/core/bkc_pkg.sv */
// Shared types for the biclique_k55_edge_check block: datapath opcodes and the
// controller/datapath command and status bundles. No dependencies.
package bkc_pkg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_FETCH,
        OP_WR_WR,
        OP_BASE_LD,
        OP_SCAN_RD,
        OP_SCAN_EV,
        OP_LOAD_X,
        OP_DFS_SKIP,
        OP_DFS_BACK,
        OP_DFS_RD,
        OP_DFS_DOWN,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic res_val;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic query;
        logic x_end;
        logic lvl_zero;
        logic lvl_top;
        logic cand_hit;
        logic pop_ok;
        logic out_free;
    } status_t;

endpackage

/* rtl/core/bkc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bkc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/bkc_datapath.sv */
// Datapath: edge matrix RAM, config registers, request latch, subset search
// registers and result register. Depends on bkc_pkg and bkc_ram.
module bkc_datapath
    import bkc_pkg::*;
#(
    parameter int MAX_SIDE = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        s_req_type,
    input  logic [4:0]  s_row,
    input  logic [4:0]  s_col,
    input  logic        s_edge_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_creates_biclique,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [5:0]  cfg_data
);

    localparam int AW = $clog2(MAX_SIDE);
    localparam int XW = $clog2(MAX_SIDE + 1);
    localparam int CW = ((XW > 6) ? XW : 6) + 1;
    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;

    logic [5:0]          rows_reg, cols_reg;
    logic                req_reg, val_reg;
    logic [4:0]          row_reg, col_reg;
    logic [XW-1:0]       x_reg;
    logic [1:0]          lvl_reg;
    logic [AW-1:0]       idx_reg [4];
    logic [MAX_SIDE-1:0] p_reg [4];
    logic [MAX_SIDE-1:0] cand_reg;
    logic                m_valid_reg, res_reg;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic [MAX_SIDE-1:0] wdata, rdata;
    logic [CW-1:0]       m_eff, n_eff, x_ext, row_ext, col_ext;
    logic [MAX_SIDE-1:0] col_bit, col_mask;
    logic [1:0]          lvl_dn;

    bkc_ram #(.WIDTH(MAX_SIDE), .DEPTH(MAX_SIDE)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign x_ext   = CW'(x_reg);
    assign row_ext = CW'(row_reg);
    assign col_ext = CW'(col_reg);
    assign m_eff   = (CW'(rows_reg) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(rows_reg);
    assign n_eff   = (CW'(cols_reg) > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : CW'(cols_reg);
    assign col_bit  = MAX_SIDE'(1) << col_reg;
    assign col_mask = ~({MAX_SIDE{1'b1}} << n_eff);
    assign lvl_dn   = lvl_reg - 2'd1;

    always_comb begin
        we    = 1'b0;
        waddr = x_reg[AW-1:0];
        wdata = '0;
        raddr = x_reg[AW-1:0];
        case (cmd.op)
            OP_CLR: begin
                we = 1'b1;
            end
            OP_FETCH: begin
                raddr = AW'(row_reg);
            end
            OP_WR_WR: begin
                we    = 1'b1;
                waddr = AW'(row_reg);
                wdata = val_reg ? (rdata | col_bit) : (rdata & ~col_bit);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        status.clr_last = (x_ext == CW'(MAX_SIDE - 1));
        status.bad      = (row_ext >= CW'(MAX_SIDE)) || (col_ext >= CW'(MAX_SIDE));
        status.query    = req_reg;
        status.x_end    = (x_ext >= m_eff);
        status.lvl_zero = (lvl_reg == 2'd0);
        status.lvl_top  = (lvl_reg == 2'd3);
        status.cand_hit = cand_reg[x_reg[AW-1:0]];
        status.pop_ok   = ($countones(p_reg[3] & rdata) >= 4);
        status.out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg    <= 6'd32;
            cols_reg    <= 6'd32;
            x_reg       <= '0;
            lvl_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == CFG_ROWS) begin
                rows_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_COLS) begin
                cols_reg <= cfg_data;
            end
            if (cmd.op == OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CLR, OP_SCAN_EV, OP_DFS_SKIP: begin
                    x_reg <= x_reg + XW'(1);
                end
                OP_LOAD, OP_BASE_LD, OP_LOAD_X: begin
                    x_reg   <= '0;
                    lvl_reg <= '0;
                end
                OP_DFS_BACK: begin
                    lvl_reg <= lvl_dn;
                    x_reg   <= XW'(idx_reg[lvl_dn]) + XW'(1);
                end
                OP_DFS_DOWN: begin
                    lvl_reg <= lvl_reg + 2'd1;
                    x_reg   <= x_reg + XW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                req_reg <= s_req_type;
                row_reg <= s_row;
                col_reg <= s_col;
                val_reg <= s_edge_value;
            end
            OP_BASE_LD: begin
                p_reg[0] <= rdata & col_mask & ~col_bit;
                cand_reg <= '0;
            end
            OP_SCAN_EV: begin
                cand_reg[x_reg[AW-1:0]] <= (x_ext != row_ext) && rdata[col_reg];
            end
            OP_DFS_DOWN: begin
                p_reg[lvl_reg + 2'd1] <= p_reg[lvl_reg] & rdata;
                idx_reg[lvl_reg]      <= x_reg[AW-1:0];
            end
            OP_OUT: begin
                res_reg <= cmd.res_val;
            end
            default: begin
            end
        endcase
    end

    assign m_valid            = m_valid_reg;
    assign m_creates_biclique = res_reg;

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_OUT |-> (!m_valid_reg || m_ready))
        else $error("result overwritten");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg)
        else $error("result dropped");
    a_rd_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DFS_RD || cmd.op == OP_SCAN_RD) |-> x_ext < CW'(MAX_SIDE))
        else $error("row index out of range");

endmodule

/* rtl/core/bkc_ctrl.sv */
// Controller FSM: clearing pass, edge write, candidate scan and 4-subset
// depth-first search sequencing. Depends on bkc_pkg.
module bkc_ctrl
    import bkc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_CLEAR   = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_FETCH   = 11'b00000000100,
        S_WR_WR   = 11'b00000001000,
        S_Q_BLD   = 11'b00000010000,
        S_SCAN_RD = 11'b00000100000,
        S_SCAN_EV = 11'b00001000000,
        S_DFS_RD  = 11'b00010000000,
        S_DFS_EV  = 11'b00100000000,
        S_RESP    = 11'b01000000000,
        S_SPARE   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   res_reg, res_next;

    always_comb begin
        state_next  = state_reg;
        res_next    = res_reg;
        cmd.op      = OP_NONE;
        cmd.res_val = res_reg;
        s_ready     = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLR;
                if (status.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                cmd.op   = OP_FETCH;
                res_next = 1'b0;
                if (status.bad) state_next = S_RESP;
                else if (status.query) state_next = S_Q_BLD;
                else state_next = S_WR_WR;
            end
            S_WR_WR: begin
                cmd.op     = OP_WR_WR;
                state_next = S_RESP;
            end
            S_Q_BLD: begin
                cmd.op     = OP_BASE_LD;
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (status.x_end) begin
                    cmd.op     = OP_LOAD_X;
                    state_next = S_DFS_RD;
                end else begin
                    cmd.op     = OP_SCAN_RD;
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                cmd.op     = OP_SCAN_EV;
                state_next = S_SCAN_RD;
            end
            S_DFS_RD: begin
                if (status.x_end) begin
                    if (status.lvl_zero) state_next = S_RESP;
                    else cmd.op = OP_DFS_BACK;
                end else if (!status.cand_hit) begin
                    cmd.op = OP_DFS_SKIP;
                end else begin
                    cmd.op     = OP_DFS_RD;
                    state_next = S_DFS_EV;
                end
            end
            S_DFS_EV: begin
                state_next = S_DFS_RD;
                if (!status.lvl_top) begin
                    cmd.op = OP_DFS_DOWN;
                end else if (status.pop_ok) begin
                    res_next   = 1'b1;
                    state_next = S_RESP;
                end else begin
                    cmd.op = OP_DFS_SKIP;
                end
            end
            S_RESP: begin
                if (status.out_free) begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            res_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_LOAD |=> state_reg == S_FETCH)
        else $error("load outside idle");
    a_out_zero_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_WR_WR |=> (state_reg == S_RESP && !res_reg))
        else $error("write answered nonzero");
    a_hit_top: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DFS_EV && !status.lvl_top |=> !res_reg)
        else $error("early hit");

endmodule

/* rtl/core/biclique_k55_edge_check.sv */
// Top level of the biclique edge completion check: controller plus datapath.
// Depends on bkc_pkg, bkc_ctrl, bkc_datapath (and bkc_ram below it).
//
//  channel  | handshake          | payload
//  s_       | s_valid / s_ready  | s_req_type, s_row, s_col, s_edge_value
//  m_       | m_valid / m_ready  | m_creates_biclique
//  cfg_     | cfg_valid / ready  | cfg_index (0 rows_in_use, 1 cols_in_use), cfg_data
//
// Edge write steps: load, read, write, result.
// Query: load, base read and the row scan, then the subset search: each
// candidate tried at each depth gets a read step and an evaluate step on
// the one read port of the edge RAM; a skipped row or a backtrack needs no
// evaluate step. Worst case near C(nc,1)+C(nc,2)+C(nc,3)+C(nc,4) tries.
// After reset a clearing pass zeroes every row of the RAM; no item is
// taken meanwhile, config writes are. One item is in work at a time;
// a finished result waits in the output register while the next item runs.
module biclique_k55_edge_check
    import bkc_pkg::*;
#(
    parameter int MAX_SIDE = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [4:0] s_row,
    input  logic [4:0] s_col,
    input  logic       s_edge_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_creates_biclique,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    bkc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bkc_datapath #(.MAX_SIDE(MAX_SIDE)) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .s_req_type         (s_req_type),
        .s_row              (s_row),
        .s_col              (s_col),
        .s_edge_value       (s_edge_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_creates_biclique (m_creates_biclique),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

endmodule
